// ===== design/line_rasterizer_assert.svh =====
// assertion macros shared by the line rasterizer modules
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

`ifndef ASSERT_OFF
`define LR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("line rasterizer check failed");
`define LR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("line rasterizer check failed");
`else
`define LR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/lr_pkg.sv =====
// shared types, constants and helpers of the line rasterizer
package lr_pkg;

	localparam int CANVAS_WIDTH  = 64;
	localparam int CANVAS_HEIGHT = 32;

	localparam int XW         = 6;
	localparam int YW         = 5;
	localparam int CHAR_W     = 8;
	localparam int COLOR_W    = 3;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;

	// error term holds values between minus dy and dx
	localparam int DIM_W = (XW > YW) ? XW : YW;
	localparam int ERR_W = DIM_W + 2;

	localparam logic [CFG_IDX_W-1:0] REG_BRUSH_CHAR  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_INDEX = CFG_IDX_W'(1);

	localparam logic [CHAR_W-1:0]  BRUSH_RESET = CHAR_W'(35);
	localparam logic [COLOR_W-1:0] COLOR_RESET = COLOR_W'(0);

	typedef struct packed {
		logic [XW-1:0] start_x;
		logic [YW-1:0] start_y;
		logic [XW-1:0] end_x;
		logic [YW-1:0] end_y;
	} line_req_t;

	typedef struct packed {
		logic [XW-1:0]      cell_x;
		logic [YW-1:0]      cell_y;
		logic [CHAR_W-1:0]  cell_char;
		logic [COLOR_W-1:0] cell_color;
		logic               is_last;
	} cell_out_t;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} lr_state_t;

	typedef struct packed {
		logic load;
		logic step;
	} lr_cmd_t;

	typedef struct packed {
		logic last;
	} lr_status_t;

	function automatic logic [XW-1:0] clamp_x(input logic [XW-1:0] v);
		return (int'(v) >= CANVAS_WIDTH) ? XW'(CANVAS_WIDTH - 1) : v;
	endfunction

	function automatic logic [YW-1:0] clamp_y(input logic [YW-1:0] v);
		return (int'(v) >= CANVAS_HEIGHT) ? YW'(CANVAS_HEIGHT - 1) : v;
	endfunction

endpackage

// ===== design/lr_ctrl.sv =====
// controller state machine of the line rasterizer
`include "line_rasterizer_assert.svh"

module lr_ctrl
	import lr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  lr_status_t status,
	output lr_cmd_t    cmd,
	output logic       busy
);

	lr_state_t state_q;
	lr_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (status.last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = start;
			end
			ST_WALK: begin
				cmd.step = 1'b1;
				busy     = 1'b1;
			end
			default: begin
				cmd  = '0;
				busy = 1'b0;
			end
		endcase
	end

	`LR_ASSERT_NXT(a_walk_ends, clk, arst_n, state_q == ST_WALK && status.last, state_q == ST_IDLE)
	`LR_ASSERT_NXT(a_walk_holds, clk, arst_n, state_q == ST_WALK && !status.last, state_q == ST_WALK)
	`LR_ASSERT_NXT(a_load_walks, clk, arst_n, cmd.load, busy && cmd.step)

endmodule

// ===== design/lr_datapath.sv =====
// coordinate registers, error term and result register of the line walk
`include "line_rasterizer_assert.svh"

module lr_datapath
	import lr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  lr_cmd_t            cmd,
	input  line_req_t          req,
	input  logic [CHAR_W-1:0]  brush_char,
	input  logic [COLOR_W-1:0] color_index,
	output lr_status_t         status,
	output cell_out_t          result,
	output logic               result_valid
);

	logic [XW-1:0]          x_q, xe_q, dx_q;
	logic [YW-1:0]          y_q, ye_q, dy_q;
	logic                   sx_neg_q, sy_neg_q;
	logic signed [ERR_W-1:0] err_q;
	logic [CHAR_W-1:0]      char_q;
	logic [COLOR_W-1:0]     color_q;
	cell_out_t              cell_q;
	logic                   strobe_q;

	logic [XW-1:0]          x0, xe0, dx0;
	logic [YW-1:0]          y0, ye0, dy0;
	logic signed [ERR_W:0]  dxe, dye, dx0e, dy0e, e2, err_d;
	logic                   move_x, move_y, last;

	always_comb begin
		x0  = clamp_x(req.start_x);
		y0  = clamp_y(req.start_y);
		xe0 = clamp_x(req.end_x);
		ye0 = clamp_y(req.end_y);
		dx0 = (x0 > xe0) ? x0 - xe0 : xe0 - x0;
		dy0 = (y0 > ye0) ? y0 - ye0 : ye0 - y0;
		dx0e = $signed({{(ERR_W + 1 - XW){1'b0}}, dx0});
		dy0e = $signed({{(ERR_W + 1 - YW){1'b0}}, dy0});
	end

	always_comb begin
		dxe    = $signed({{(ERR_W + 1 - XW){1'b0}}, dx_q});
		dye    = $signed({{(ERR_W + 1 - YW){1'b0}}, dy_q});
		e2     = $signed({err_q, 1'b0});
		move_x = e2 > -dye;
		move_y = e2 < dxe;
		err_d  = $signed({err_q[ERR_W-1], err_q}) - (move_x ? dye : '0) + (move_y ? dxe : '0);
		last   = (x_q == xe_q) && (y_q == ye_q);
	end

	assign status.last = last;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q      <= x0;
			y_q      <= y0;
			xe_q     <= xe0;
			ye_q     <= ye0;
			dx_q     <= dx0;
			dy_q     <= dy0;
			sx_neg_q <= !(x0 < xe0);
			sy_neg_q <= !(y0 < ye0);
			err_q    <= $signed(ERR_W'(dx0e - dy0e));
			char_q   <= brush_char;
			color_q  <= color_index;
		end else if (cmd.step && !last) begin
			err_q <= $signed(err_d[ERR_W-1:0]);
			if (move_x) begin
				x_q <= sx_neg_q ? x_q - XW'(1) : x_q + XW'(1);
			end
			if (move_y) begin
				y_q <= sy_neg_q ? y_q - YW'(1) : y_q + YW'(1);
			end
		end
	end

	// result register: one beat per walk step
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			cell_q.cell_x     <= x_q;
			cell_q.cell_y     <= y_q;
			cell_q.cell_char  <= char_q;
			cell_q.cell_color <= color_q;
			cell_q.is_last    <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.step;
		end
	end

	assign result       = cell_q;
	assign result_valid = strobe_q;

	`LR_ASSERT_NXT(a_gap_after_last, clk, arst_n, strobe_q && cell_q.is_last, !strobe_q)
	`LR_ASSERT_NXT(a_walk_moves, clk, arst_n, cmd.step && !last, x_q != $past(x_q) || y_q != $past(y_q))
	`LR_ASSERT_IMP(a_x_in_canvas, clk, arst_n, strobe_q, int'(cell_q.cell_x) < CANVAS_WIDTH)

endmodule

// ===== design/line_rasterizer.sv =====
// line rasterizer top level: configuration registers, controller and datapath
//
// A request is a packed start and end cell on req, accepted at a rising edge
// with start high and busy low. The block then walks the Bresenham path and
// puts one cell per cycle on result, marked by result_valid for exactly one
// cycle; the end cell carries is_last. A line of n = max(|dx|,|dy|)+1 cells
// (1 to 64) keeps busy high while it is walked; the first cell passes the
// walk state register and then the result register before it is shown, and
// the last cell shows in the cycle busy falls. A new request may be accepted
// in the cycle the last cell shows. The walk loop advances one cell per
// clock.
// The receiver cannot stall: each beat is taken in the cycle it is shown.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
// the brush character, index 1 the palette index, other indices are ignored.
// cfg_ready is always high; write only while no line is in progress. Brush
// and color are sampled when a request is accepted.
// Reset (arst_n low) returns the walker to idle, drops result_valid, and sets
// the brush character to 35 and the palette index to 0.

module line_rasterizer
	import lr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  line_req_t             req,
	output logic                  result_valid,
	output cell_out_t             result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [CHAR_W-1:0]  brush_q;
	logic [COLOR_W-1:0] color_q;
	lr_cmd_t            cmd;
	lr_status_t         status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brush_q <= BRUSH_RESET;
			color_q <= COLOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BRUSH_CHAR:  brush_q <= cfg_data[CHAR_W-1:0];
				REG_COLOR_INDEX: color_q <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	lr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	lr_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.req          (req),
		.brush_char   (brush_q),
		.color_index  (color_q),
		.status       (status),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule
